/* hw/rtl/ncr_pkg.sv */
// Shared types, constants and fixed-point helpers of the Newton cubic root finder.
package ncr_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned GUESS_W    = 32;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned STEPS_W    = 8;
  localparam int unsigned OUTC_W     = 2;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd66;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE  = 1'b0,
    REG_ITER_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_CONVERGED  = 2'd0,
    OUTC_ZERO_DERIV = 2'd1,
    OUTC_LIMIT      = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_ISSUE,
    ST_SQ_WAIT,
    ST_CB_ISSUE,
    ST_CB_WAIT,
    ST_F_SUB,
    ST_F_ADD,
    ST_D_DBL,
    ST_D_TRI,
    ST_D_XX,
    ST_D_SUB,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } core_state_e;

  typedef struct packed {
    logic signed [GUESS_W-1:0] start_guess;
  } in_item_t;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root_estimate;
    logic [STEPS_W-1:0]       steps_taken;
    logic [OUTC_W-1:0]        outcome;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  // Two's complement magnitude; the most negative value maps to 2^63.
  function automatic logic [WIDE_W-1:0] mag(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] u;
    u = v;
    mag = u[WIDE_W-1] ? (~u + WIDE_W'(1)) : u;
  endfunction

  // Rebuild a signed value from magnitude and sign, saturating.
  function automatic logic signed [WIDE_W-1:0] from_mag(input logic [WIDE_W-1:0] m,
                                                        input logic neg,
                                                        input logic over);
    if (over || m[WIDE_W-1]) begin
      from_mag = neg ? WIDE_MIN : WIDE_MAX;
    end else if (neg) begin
      from_mag = signed'(~m + WIDE_W'(1));
    end else begin
      from_mag = signed'(m);
    end
  endfunction

  // Saturating add or subtract on the wide format.
  function automatic logic signed [WIDE_W-1:0] sat_addsub(input logic signed [WIDE_W-1:0] a,
                                                          input logic signed [WIDE_W-1:0] b,
                                                          input logic sub);
    logic [WIDE_W:0] s;
    if (sub) begin
      s = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
    end else begin
      s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    end
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      sat_addsub = s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
    end else begin
      sat_addsub = signed'(s[WIDE_W-1:0]);
    end
  endfunction

  // Clamp a wide value to the signed range of w bits (w at most WIDE_W).
  function automatic logic signed [WIDE_W-1:0] clamp_to(input logic signed [WIDE_W-1:0] v,
                                                        input int unsigned w);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = signed'((WIDE_W'(1) << (w - 1)) - WIDE_W'(1));
    lo = ~hi;
    if (v > hi) begin
      clamp_to = hi;
    end else if (v < lo) begin
      clamp_to = lo;
    end else begin
      clamp_to = v;
    end
  endfunction

endpackage

/* hw/rtl/ncr_stream_if.sv */
// Valid/ready channel interface with a typed payload.
interface ncr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/newton_cubic_root_finder_unit.sv */
// Top level of the Newton root finder for the cubic x^3 - x^2 + 2.
//
// Channels: guess_if takes one item per root search (signed Q.FRAC_BITS start
// guess). result_if returns one item per search: the saturated root estimate,
// the number of Newton updates made, and an outcome (converged, zero
// derivative, iteration limit). cfg_if writes the tolerance (index 0) and the
// iteration limit (index 1); it is always ready.
// Each Newton round runs two four-pass multiplies (x^2, then x^3), the
// adder steps and the bit-serial divider. A search that stops at a zero
// derivative skips the divider of its last round; a small first step or a
// zero limit ends the search before any update. At most 255 updates.
// Throughput: one item at a time; guess_if is ready only while the sequencer
// is idle. A finished result moves into the output register, so the next
// item can be accepted while the receiver has not yet taken the last one.
// Receiver stall: the result is held in the output register; a second result
// waits in the sequencer, which then takes no new item.
// Reset: tolerance returns to 66, the limit to 64, no result is pending and
// the sequencer is idle.
module newton_cubic_root_finder_unit #(
  parameter int unsigned FRAC_BITS  = ncr_pkg::FRAC_BITS_DEF,
  parameter int unsigned DATA_WIDTH = ncr_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ncr_stream_if.sink    guess_if,
  ncr_stream_if.source  result_if,
  ncr_stream_if.sink    cfg_if
);

  logic [ncr_pkg::TOL_W-1:0]   tol_q, tol_d;
  logic [ncr_pkg::LIMIT_W-1:0] limit_q, limit_d;

  logic               out_valid_q;
  ncr_pkg::out_item_t out_data_q;

  ncr_pkg::core_stat_t core_stat;
  ncr_pkg::out_item_t  core_result;
  ncr_pkg::in_item_t   guess_item;
  ncr_pkg::cfg_item_t  cfg_item;
  logic                core_start;
  logic                take;

  assign guess_item = guess_if.data;
  assign cfg_item   = cfg_if.data;

  // Accept a new guess only when the sequencer is free.
  assign guess_if.ready = core_stat.idle;
  assign core_start     = guess_if.valid && core_stat.idle;

  // Move a finished result into the output register once it is empty or draining.
  assign take = core_stat.done && (!out_valid_q || result_if.ready);

  ncr_core #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (core_start),
    .guess_i     (guess_item.start_guess),
    .tolerance_i (tol_q),
    .limit_i     (limit_q),
    .take_i      (take),
    .stat_o      (core_stat),
    .result_o    (core_result)
  );

  // Configuration writes: keep only the bits each register holds.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    tol_d   = tol_q;
    limit_d = limit_q;
    if (cfg_if.valid) begin
      unique case (ncr_pkg::cfg_reg_e'(cfg_item.index))
        ncr_pkg::REG_TOLERANCE:  tol_d   = cfg_item.value[ncr_pkg::TOL_W-1:0];
        ncr_pkg::REG_ITER_LIMIT: limit_d = cfg_item.value[ncr_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= ncr_pkg::TOL_RESET;
      limit_q     <= ncr_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      tol_q   <= tol_d;
      limit_q <= limit_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (result_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the payload until the receiver takes the item.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= core_result;
    end
  end

  assign result_if.valid = out_valid_q;
  assign result_if.data  = out_data_q;

endmodule

/* hw/rtl/ncr_mul.sv */
// Fixed-point signed multiplier built from four 32x32 partial products over several cycles.
module ncr_mul #(
  parameter int unsigned FRAC_BITS = ncr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ncr_pkg::WIDE_W-1:0] a_i,
  input  logic signed [ncr_pkg::WIDE_W-1:0] b_i,
  output logic                              done_o,
  output logic signed [ncr_pkg::WIDE_W-1:0] prod_o
);

  localparam int unsigned W     = ncr_pkg::WIDE_W;
  localparam int unsigned HALF  = W / 2;
  localparam int unsigned PROD  = 2 * W;

  logic [W-1:0]    ua_q, ub_q;
  logic            neg_q;
  logic            busy_q;
  logic [2:0]      phase_q;
  logic [W-1:0]    pp_q;
  logic [1:0]      pp_sel_q;
  logic            pp_vld_q;
  logic [PROD-1:0] acc_q;
  logic            done_q;

  logic [HALF-1:0] a_half, b_half;
  logic [PROD-1:0] pp_shifted;
  logic            issue;

  assign issue  = busy_q && !phase_q[2];
  assign a_half = phase_q[0] ? ua_q[W-1:HALF] : ua_q[HALF-1:0];
  assign b_half = phase_q[1] ? ub_q[W-1:HALF] : ub_q[HALF-1:0];

  always_comb begin
    unique case (pp_sel_q)
      2'd0:    pp_shifted = {{W{1'b0}}, pp_q};
      2'd1,
      2'd2:    pp_shifted = {{HALF{1'b0}}, pp_q, {HALF{1'b0}}};
      default: pp_shifted = {pp_q, {W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      phase_q  <= '0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      pp_vld_q <= issue;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
      end else if (issue) begin
        phase_q <= phase_q + 3'd1;
      end
      if (pp_vld_q && (pp_sel_q == 2'd3)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= ncr_pkg::mag(a_i);
      ub_q  <= ncr_pkg::mag(b_i);
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_shifted;
    end
    if (issue) begin
      pp_q     <= W'(a_half * b_half);
      pp_sel_q <= phase_q[1:0];
    end
  end

  assign done_o = done_q;
  assign prod_o = ncr_pkg::from_mag(acc_q[W+FRAC_BITS-1:FRAC_BITS], neg_q,
                                    |acc_q[PROD-1:W+FRAC_BITS]);

endmodule

/* hw/rtl/ncr_div.sv */
// Bit-serial restoring divider for signed fixed-point quotients, one bit per cycle.
module ncr_div #(
  parameter int unsigned FRAC_BITS = ncr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ncr_pkg::WIDE_W-1:0] num_i,
  input  logic signed [ncr_pkg::WIDE_W-1:0] den_i,
  output logic                              done_o,
  output logic signed [ncr_pkg::WIDE_W-1:0] quot_o
);

  localparam int unsigned W     = ncr_pkg::WIDE_W;
  localparam int unsigned DVD_W = W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [W-1:0]     rem_q, ud_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [W:0] trial, diff;
  logic       ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, ud_q};
  assign ge    = !diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out at the top and the quotient bits in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {ncr_pkg::mag(num_i), {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      ud_q  <= ncr_pkg::mag(den_i);
      neg_q <= num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = ncr_pkg::from_mag(dvd_q[W-1:0], neg_q, |dvd_q[DVD_W-1:W]);

endmodule

/* hw/rtl/ncr_core.sv */
// Newton iteration sequencer with a shared saturating adder, multiplier and divider.
module ncr_core #(
  parameter int unsigned FRAC_BITS  = ncr_pkg::FRAC_BITS_DEF,
  parameter int unsigned DATA_WIDTH = ncr_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ncr_pkg::GUESS_W-1:0] guess_i,
  input  logic [ncr_pkg::TOL_W-1:0]          tolerance_i,
  input  logic [ncr_pkg::LIMIT_W-1:0]        limit_i,
  input  logic                               take_i,
  output ncr_pkg::core_stat_t                stat_o,
  output ncr_pkg::out_item_t                 result_o
);

  localparam int unsigned W = ncr_pkg::WIDE_W;
  localparam logic signed [W-1:0] TWO = W'(2) << FRAC_BITS;

  ncr_pkg::core_state_e state_q, state_d;

  logic signed [DATA_WIDTH-1:0] x_q, x_d;
  logic signed [W-1:0] x2_q, x2_d, x3_q, x3_d, f_q, f_d, fd_q, fd_d, m_q, m_d;
  logic [ncr_pkg::STEPS_W-1:0] steps_q, steps_d;
  logic small_q, small_d;
  ncr_pkg::outcome_e outc_q, outc_d;

  logic signed [W-1:0] x_wide, guess_wide, guess_clamp, alu_a, alu_b, alu_y, upd_clamp;
  logic signed [W-1:0] root_clamp;
  logic alu_sub;
  logic is_small;
  logic mul_start, mul_done, div_start, div_done;
  logic signed [W-1:0] mul_a, mul_prod, div_quot;

  assign x_wide      = {{(W-DATA_WIDTH){x_q[DATA_WIDTH-1]}}, x_q};
  assign guess_wide  = {{(W-ncr_pkg::GUESS_W){guess_i[ncr_pkg::GUESS_W-1]}}, guess_i};
  assign guess_clamp = ncr_pkg::clamp_to(guess_wide, DATA_WIDTH);
  assign alu_y       = ncr_pkg::sat_addsub(alu_a, alu_b, alu_sub);
  assign upd_clamp   = ncr_pkg::clamp_to(alu_y, DATA_WIDTH);
  assign root_clamp  = ncr_pkg::clamp_to(x_wide, ncr_pkg::ROOT_W);
  assign is_small    = ncr_pkg::mag(m_q) < {{(W-ncr_pkg::TOL_W){1'b0}}, tolerance_i};

  assign mul_a = (state_q == ncr_pkg::ST_CB_ISSUE) ? x2_q : x_wide;

  ncr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (x_wide),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ncr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (f_q),
    .den_i   (fd_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    x2_d      = x2_q;
    x3_d      = x3_q;
    f_d       = f_q;
    fd_d      = fd_q;
    m_d       = m_q;
    steps_d   = steps_q;
    small_d   = small_q;
    outc_d    = outc_q;
    alu_a     = x2_q;
    alu_b     = x2_q;
    alu_sub   = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ncr_pkg::ST_IDLE: begin
        if (start_i) begin
          x_d     = guess_clamp[DATA_WIDTH-1:0];
          steps_d = '0;
          state_d = ncr_pkg::ST_SQ_ISSUE;
        end
      end
      ncr_pkg::ST_SQ_ISSUE: begin
        mul_start = 1'b1;
        state_d   = ncr_pkg::ST_SQ_WAIT;
      end
      ncr_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          x2_d    = mul_prod;
          state_d = ncr_pkg::ST_CB_ISSUE;
        end
      end
      ncr_pkg::ST_CB_ISSUE: begin
        mul_start = 1'b1;
        state_d   = ncr_pkg::ST_CB_WAIT;
      end
      ncr_pkg::ST_CB_WAIT: begin
        if (mul_done) begin
          x3_d    = mul_prod;
          state_d = ncr_pkg::ST_F_SUB;
        end
      end
      ncr_pkg::ST_F_SUB: begin
        alu_a   = x3_q;
        alu_sub = 1'b1;
        f_d     = alu_y;
        state_d = ncr_pkg::ST_F_ADD;
      end
      ncr_pkg::ST_F_ADD: begin
        alu_a   = f_q;
        alu_b   = TWO;
        f_d     = alu_y;
        state_d = ncr_pkg::ST_D_DBL;
      end
      ncr_pkg::ST_D_DBL: begin
        fd_d    = alu_y;
        state_d = ncr_pkg::ST_D_TRI;
      end
      ncr_pkg::ST_D_TRI: begin
        alu_a   = fd_q;
        fd_d    = alu_y;
        state_d = ncr_pkg::ST_D_XX;
      end
      ncr_pkg::ST_D_XX: begin
        // x3 is spent by now; reuse it for 2x
        alu_a   = x_wide;
        alu_b   = x_wide;
        x3_d    = alu_y;
        state_d = ncr_pkg::ST_D_SUB;
      end
      ncr_pkg::ST_D_SUB: begin
        alu_a   = fd_q;
        alu_b   = x3_q;
        alu_sub = 1'b1;
        fd_d    = alu_y;
        state_d = ncr_pkg::ST_CHECK;
      end
      ncr_pkg::ST_CHECK: begin
        if (fd_q == '0) begin
          outc_d  = ncr_pkg::OUTC_ZERO_DERIV;
          state_d = ncr_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ncr_pkg::ST_DIV_WAIT;
        end
      end
      ncr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          m_d     = div_quot;
          state_d = ncr_pkg::ST_DECIDE;
        end
      end
      ncr_pkg::ST_DECIDE: begin
        small_d = is_small;
        // A small first step returns the guess untouched.
        priority if (steps_q == '0 && is_small) begin
          outc_d  = ncr_pkg::OUTC_CONVERGED;
          state_d = ncr_pkg::ST_DONE;
        end else if (steps_q == '0 && limit_i == '0) begin
          outc_d  = ncr_pkg::OUTC_LIMIT;
          state_d = ncr_pkg::ST_DONE;
        end else begin
          state_d = ncr_pkg::ST_UPDATE;
        end
      end
      ncr_pkg::ST_UPDATE: begin
        alu_a   = x_wide;
        alu_b   = m_q;
        alu_sub = 1'b1;
        x_d     = upd_clamp[DATA_WIDTH-1:0];
        steps_d = steps_q + ncr_pkg::STEPS_W'(1);
        priority if (small_q) begin
          outc_d  = ncr_pkg::OUTC_CONVERGED;
          state_d = ncr_pkg::ST_DONE;
        end else if ({1'b0, steps_q} + 9'd1 >= {1'b0, limit_i}) begin
          outc_d  = ncr_pkg::OUTC_LIMIT;
          state_d = ncr_pkg::ST_DONE;
        end else begin
          state_d = ncr_pkg::ST_SQ_ISSUE;
        end
      end
      ncr_pkg::ST_DONE: begin
        if (take_i) begin
          state_d = ncr_pkg::ST_IDLE;
        end
      end
      default: state_d = ncr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncr_pkg::ST_IDLE;
      steps_q <= '0;
      small_q <= 1'b0;
      outc_q  <= ncr_pkg::OUTC_CONVERGED;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      small_q <= small_d;
      outc_q  <= outc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    x2_q <= x2_d;
    x3_q <= x3_d;
    f_q  <= f_d;
    fd_q <= fd_d;
    m_q  <= m_d;
  end

  assign stat_o.idle = (state_q == ncr_pkg::ST_IDLE);
  assign stat_o.done = (state_q == ncr_pkg::ST_DONE);

  assign result_o.root_estimate = root_clamp[ncr_pkg::ROOT_W-1:0];
  assign result_o.steps_taken   = steps_q;
  assign result_o.outcome       = outc_q;

endmodule

/* hw/rtl/ncr_checker.sv */
// Port-level checks of the root finder, bound to the top level.
module ncr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [ncr_pkg::ROOT_W-1:0]  out_root_i,
  input logic [ncr_pkg::STEPS_W-1:0]        out_steps_i,
  input logic [ncr_pkg::OUTC_W-1:0]         out_outcome_i
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_root_i)
      && $stable(out_steps_i) && $stable(out_outcome_i))
    else $error("result changed while stalled");

  // An accepted item occupies the block for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accepting an item");

  // No result can appear in the cycle after an item enters an empty block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result too early");

  // Ready returns only when a finished result has moved to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i)
    else $error("ready returned without a result");

endmodule

bind newton_cubic_root_finder_unit ncr_checker u_ncr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (guess_if.valid),
  .in_ready_i    (guess_if.ready),
  .out_valid_i   (result_if.valid),
  .out_ready_i   (result_if.ready),
  .out_root_i    (result_if.data.root_estimate),
  .out_steps_i   (result_if.data.steps_taken),
  .out_outcome_i (result_if.data.outcome)
);
